// ===== hdl/rmq_pkg.sv =====
package rmq_pkg;

  localparam int unsigned InW  = 16;
  localparam int unsigned OutW = 16;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  localparam logic signed [OutW-1:0] SatMax = 16'sh7fff;
  localparam logic signed [OutW-1:0] SatMin = -16'sh8000;

endpackage

// ===== hdl/rmq_sqrt.sv =====
module rmq_sqrt #(
  parameter int unsigned RadW  = 48,
  parameter int unsigned RootW = 24,
  parameter int unsigned TagW  = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [RadW-1:0] rad_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [RootW-1:0] root_o,
  output logic [TagW-1:0] tag_o
);

  logic [RootW:0][RadW+1:0]  rem_q;
  logic [RootW:0][RadW-1:0]  rad_q;
  logic [RootW:0][RootW-1:0] root_q;
  logic [RootW:0][TagW-1:0]  tag_q;
  logic [RootW:0]            vld_q;

  always_comb begin
    rem_q[0]  = '0;
    rad_q[0]  = rad_i;
    root_q[0] = '0;
    tag_q[0]  = tag_i;
    vld_q[0]  = valid_i;
  end

  for (genvar g = 0; g < RootW; g++) begin : g_step
    logic [RadW+1:0]  rem_sh;
    logic [RadW+1:0]  trial;
    logic [RadW+1:0]  rem_d;
    logic [RootW-1:0] root_d;
    logic [RadW+1:0]  rem_r;
    logic [RadW-1:0]  rad_r;
    logic [RootW-1:0] root_r;
    logic [TagW-1:0]  tag_r;
    logic             vld_r;

    always_comb begin
      rem_sh = {rem_q[g][RadW-1:0], rad_q[g][RadW-1 -: 2]};
      trial  = {{(RadW+2-RootW-2){1'b0}}, root_q[g], 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[g][RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[g][RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_r <= 1'b0;
      end else if (en_i) begin
        vld_r <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r  <= rem_d;
        rad_r  <= {rad_q[g][RadW-3:0], 2'b00};
        root_r <= root_d;
        tag_r  <= tag_q[g];
      end
    end

    always_comb begin
      rem_q[g+1]  = rem_r;
      rad_q[g+1]  = rad_r;
      root_q[g+1] = root_r;
      tag_q[g+1]  = tag_r;
      vld_q[g+1]  = vld_r;
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = root_q[RootW];
  assign tag_o   = tag_q[RootW];

endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// Three front stages, RootW root stages, FRAC_BITS + 19 divider stages and an output register,
// with RootW = (RadInW + FRAC_BITS + 1) / 2. Throughput: one matrix per cycle while the output
// is not stalled; a restoring square root and three restoring dividers are fully pipelined,
// one result bit per stage.
// A stall on the output freezes the whole pipeline.
// Reset clears the valid bits only; the data registers are not reset.
module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, degenerate, zero fill
  output logic [71:0]  m_axis_tdata
);

  localparam int unsigned InW   = rmq_pkg::InW;
  localparam int unsigned RadInW = (FRAC_BITS > 16) ? (FRAC_BITS + 3) : 20;
  localparam int unsigned RadW  = 2 * ((RadInW + FRAC_BITS + 1) / 2);
  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned NumW  = 19 + FRAC_BITS;
  localparam int unsigned QW    = NumW;
  localparam int unsigned DivW  = RootW + 1;

  typedef struct packed {
    logic                     deg;
    logic [1:0]               sel;
    logic                     pos;
    logic signed [NumW-1:0]   na;
    logic signed [NumW-1:0]   nb;
    logic signed [NumW-1:0]   nc;
  } ctx_t;

  localparam int unsigned CtxW = $bits(ctx_t);

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [InW-1:0] m [3][3];
  for (genvar r = 0; r < 3; r++) begin : g_r
    for (genvar c = 0; c < 3; c++) begin : g_c
      assign m[r][c] = s_axis_tdata[(r*3+c)*InW +: InW];
    end
  end

  // Stage 1: register inputs.
  logic signed [InW-1:0] m1_q [3][3];
  logic                  v1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q <= m;
    end
  end

  // Stage 2: trace, pick and sums.
  logic signed [17:0] tr_d;
  logic [1:0]         pick_d;
  logic signed [17:0] dii, djj, dkk;
  logic signed [16:0] sa, sb, sc;
  logic [1:0]         ii, jj, kk;
  logic signed [RadInW-1:0] rad_d;

  always_comb begin
    tr_d = 18'(m1_q[0][0]) + 18'(m1_q[1][1]) + 18'(m1_q[2][2]);
    pick_d = rmq_pkg::AXIS_X;
    if (m1_q[1][1] > m1_q[0][0]) pick_d = rmq_pkg::AXIS_Y;
    if (m1_q[2][2] > m1_q[pick_d][pick_d]) pick_d = rmq_pkg::AXIS_Z;
    ii = pick_d;
    jj = (ii == 2'd2) ? 2'd0 : ii + 2'd1;
    kk = (jj == 2'd2) ? 2'd0 : jj + 2'd1;
    dii = 18'(m1_q[ii][ii]);
    djj = 18'(m1_q[jj][jj]);
    dkk = 18'(m1_q[kk][kk]);
    if (tr_d > 0) begin
      rad_d = RadInW'(tr_d) + (RadInW'(1) <<< FRAC_BITS);
      sa = 17'(m1_q[2][1]) - 17'(m1_q[1][2]);
      sb = 17'(m1_q[0][2]) - 17'(m1_q[2][0]);
      sc = 17'(m1_q[1][0]) - 17'(m1_q[0][1]);
    end else begin
      rad_d = RadInW'(dii) - (RadInW'(djj) + RadInW'(dkk)) + (RadInW'(1) <<< FRAC_BITS);
      sa = 17'(m1_q[kk][jj]) - 17'(m1_q[jj][kk]);
      sb = 17'(m1_q[jj][ii]) + 17'(m1_q[ii][jj]);
      sc = 17'(m1_q[kk][ii]) + 17'(m1_q[ii][kk]);
    end
  end

  logic                      v2_q;
  logic signed [RadInW-1:0]  rad2_q;
  ctx_t                      ctx2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rad2_q     <= rad_d;
      ctx2_q.pos <= tr_d > 0;
      ctx2_q.sel <= pick_d;
      ctx2_q.deg <= !(tr_d > 0) && (rad_d <= 0);
      ctx2_q.na  <= NumW'(sa) <<< FRAC_BITS;
      ctx2_q.nb  <= NumW'(sb) <<< FRAC_BITS;
      ctx2_q.nc  <= NumW'(sc) <<< FRAC_BITS;
    end
  end

  // Stage 3: radicand into Q.28.
  logic            v3_q;
  logic [RadW-1:0] rad3_q;
  ctx_t            ctx3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rad3_q <= ctx2_q.deg ? RadW'(1) : (RadW'(unsigned'(rad2_q)) << FRAC_BITS);
      ctx3_q <= ctx2_q;
    end
  end

  logic             sq_vld;
  logic [RootW-1:0] sq_root;
  logic [CtxW-1:0]  sq_tag;

  rmq_sqrt #(.RadW(RadW), .RootW(RootW), .TagW(CtxW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (rad3_q),
    .tag_i   (CtxW'(ctx3_q)),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  // Three pipelined restoring dividers on magnitudes, sign restored at the end.
  logic [QW:0][2:0][NumW-1:0] dn_q;
  logic [QW:0][2:0][DivW:0]   dr_q;
  logic [QW:0][2:0][QW-1:0]   dq_q;
  logic [QW:0][DivW-1:0]      dd_q;
  logic [QW:0][RootW-1:0]     ds_q;
  logic [QW:0][CtxW-1:0]      dt_q;
  logic [QW:0]                dv_q;

  ctx_t sq_ctx;
  assign sq_ctx = ctx_t'(sq_tag);

  always_comb begin
    dn_q[0][0] = sq_ctx.na[NumW-1] ? NumW'(-sq_ctx.na) : NumW'(sq_ctx.na);
    dn_q[0][1] = sq_ctx.nb[NumW-1] ? NumW'(-sq_ctx.nb) : NumW'(sq_ctx.nb);
    dn_q[0][2] = sq_ctx.nc[NumW-1] ? NumW'(-sq_ctx.nc) : NumW'(sq_ctx.nc);
    dr_q[0] = '0;
    dq_q[0] = '0;
    dd_q[0] = {sq_root, 1'b0};
    ds_q[0] = sq_root;
    dt_q[0] = sq_tag;
    dv_q[0] = sq_vld;
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    logic [2:0][NumW-1:0] n_r;
    logic [2:0][DivW:0]   r_r;
    logic [2:0][QW-1:0]   q_r;
    logic [DivW-1:0]      d_r;
    logic [RootW-1:0]     s_r;
    logic [CtxW-1:0]      t_r;
    logic                 v_r;
    logic [2:0][DivW:0]   r_d;
    logic [2:0][QW-1:0]   q_d;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        logic [DivW:0] sh;
        sh = {dr_q[g][l][DivW-1:0], dn_q[g][l][NumW-1]};
        if (sh >= {1'b0, dd_q[g]}) begin
          r_d[l] = sh - {1'b0, dd_q[g]};
          q_d[l] = {dq_q[g][l][QW-2:0], 1'b1};
        end else begin
          r_d[l] = sh;
          q_d[l] = {dq_q[g][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= dv_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          n_r[l] <= {dn_q[g][l][NumW-2:0], 1'b0};
        end
        r_r <= r_d;
        q_r <= q_d;
        d_r <= dd_q[g];
        s_r <= ds_q[g];
        t_r <= dt_q[g];
      end
    end

    always_comb begin
      dn_q[g+1] = n_r;
      dr_q[g+1] = r_r;
      dq_q[g+1] = q_r;
      dd_q[g+1] = d_r;
      ds_q[g+1] = s_r;
      dt_q[g+1] = t_r;
      dv_q[g+1] = v_r;
    end
  end

  // Final stage: signs, placement, saturation.
  ctx_t fc;
  assign fc = ctx_t'(dt_q[QW]);

  function automatic logic signed [15:0] sat(input logic signed [QW:0] v);
    if (v > (QW+1)'(rmq_pkg::SatMax)) return rmq_pkg::SatMax;
    if (v < (QW+1)'(rmq_pkg::SatMin)) return rmq_pkg::SatMin;
    return v[15:0];
  endfunction

  logic signed [QW:0] qa, qb, qc, qh;
  logic signed [15:0] ow, ox, oy, oz;

  always_comb begin
    qa = fc.na[NumW-1] ? -$signed({1'b0, dq_q[QW][0]}) : $signed({1'b0, dq_q[QW][0]});
    qb = fc.nb[NumW-1] ? -$signed({1'b0, dq_q[QW][1]}) : $signed({1'b0, dq_q[QW][1]});
    qc = fc.nc[NumW-1] ? -$signed({1'b0, dq_q[QW][2]}) : $signed({1'b0, dq_q[QW][2]});
    qh = $signed((QW+1)'(ds_q[QW] >> 1));
    ow = sat(qa);
    ox = sat(qb);
    oy = sat(qc);
    oz = '0;
    if (fc.pos) begin
      ow = sat(qh);
      ox = sat(qa);
      oy = sat(qb);
      oz = sat(qc);
    end else begin
      unique case (fc.sel)
        rmq_pkg::AXIS_X: begin
          ox = sat(qh); oy = sat(qb); oz = sat(qc);
        end
        rmq_pkg::AXIS_Y: begin
          oy = sat(qh); oz = sat(qb); ox = sat(qc);
        end
        default: begin
          oz = sat(qh); ox = sat(qb); oy = sat(qc);
        end
      endcase
      ow = sat(qa);
    end
    if (fc.deg) begin
      ow = '0; ox = '0; oy = '0; oz = '0;
    end
  end

  logic [71:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_q[QW];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {7'b0, fc.deg, oz, oy, ox, ow};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
